// ===== sv/sgrcat_pkg.sv =====
package sgrcat_pkg;

    localparam int unsigned CODE_BITS = 32;
    localparam int unsigned HELD_MAX_BITS = 16;

    localparam logic [23:0] WHITE = 24'hFFFFFF;
    localparam logic [23:0] BLACK = 24'h000000;
    localparam logic [23:0] BRIGHT = 24'h555555;

    localparam logic [CODE_BITS-1:0] CODE_RESET = 32'd0;
    localparam logic [CODE_BITS-1:0] CODE_INVERSE_ON = 32'd7;
    localparam logic [CODE_BITS-1:0] CODE_INVERSE_OFF = 32'd27;
    localparam logic [CODE_BITS-1:0] CODE_FG_BASE = 32'd30;
    localparam logic [CODE_BITS-1:0] CODE_FG_LAST = 32'd37;
    localparam logic [CODE_BITS-1:0] CODE_FG_EXT = 32'd38;
    localparam logic [CODE_BITS-1:0] CODE_FG_DEFAULT = 32'd39;
    localparam logic [CODE_BITS-1:0] CODE_BG_BASE = 32'd40;
    localparam logic [CODE_BITS-1:0] CODE_BG_LAST = 32'd47;
    localparam logic [CODE_BITS-1:0] CODE_BG_EXT = 32'd48;
    localparam logic [CODE_BITS-1:0] CODE_BG_DEFAULT = 32'd49;
    localparam logic [CODE_BITS-1:0] CODE_FG_BRIGHT_BASE = 32'd90;
    localparam logic [CODE_BITS-1:0] CODE_FG_BRIGHT_LAST = 32'd97;
    localparam logic [CODE_BITS-1:0] CODE_BG_BRIGHT_BASE = 32'd100;
    localparam logic [CODE_BITS-1:0] CODE_BG_BRIGHT_LAST = 32'd107;
    localparam logic [CODE_BITS-1:0] SEL_INDEXED = 32'd5;
    localparam logic [CODE_BITS-1:0] SEL_DIRECT = 32'd2;

    localparam logic [7:0] CUBE_FIRST = 8'd16;
    localparam logic [7:0] GRAY_FIRST = 8'd232;

    typedef struct packed {
        logic [23:0] fg;
        logic [23:0] bg;
        logic        inv;
    } attr_t;

    function automatic logic [23:0] palette(input logic [2:0] idx);
        logic [23:0] rgb;
        case (idx)
            3'd0: rgb = 24'h000000;
            3'd1: rgb = 24'hAA0000;
            3'd2: rgb = 24'h00AA00;
            3'd3: rgb = 24'hAA5500;
            3'd4: rgb = 24'h0000AA;
            3'd5: rgb = 24'hAA00AA;
            3'd6: rgb = 24'h00AAAA;
            3'd7: rgb = 24'hAAAAAA;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

    function automatic attr_t plain_code(input attr_t a, input logic [CODE_BITS-1:0] p);
        attr_t r;
        logic [CODE_BITS-1:0] d_fg;
        logic [CODE_BITS-1:0] d_bg;
        logic [CODE_BITS-1:0] d_fgb;
        logic [CODE_BITS-1:0] d_bgb;
        r = a;
        d_fg = p - CODE_FG_BASE;
        d_bg = p - CODE_BG_BASE;
        d_fgb = p - CODE_FG_BRIGHT_BASE;
        d_bgb = p - CODE_BG_BRIGHT_BASE;
        if (p == CODE_RESET) begin
            r.fg = WHITE;
            r.bg = BLACK;
            r.inv = 1'b0;
        end else if (p inside {[CODE_FG_BASE:CODE_FG_LAST]}) begin
            r.fg = palette(d_fg[2:0]);
        end else if (p inside {[CODE_BG_BASE:CODE_BG_LAST]}) begin
            r.bg = palette(d_bg[2:0]);
        end else if (p == CODE_FG_DEFAULT) begin
            r.fg = WHITE;
        end else if (p == CODE_BG_DEFAULT) begin
            r.bg = BLACK;
        end else if (p inside {[CODE_FG_BRIGHT_BASE:CODE_FG_BRIGHT_LAST]}) begin
            r.fg = palette(d_fgb[2:0]) | BRIGHT;
        end else if (p inside {[CODE_BG_BRIGHT_BASE:CODE_BG_BRIGHT_LAST]}) begin
            r.bg = palette(d_bgb[2:0]) | BRIGHT;
        end else if (p == CODE_INVERSE_ON) begin
            r.inv = 1'b1;
        end else if (p == CODE_INVERSE_OFF) begin
            r.inv = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] cube_level(input logic [2:0] v);
        return (v == 3'd0) ? 8'd0 : 8'(v) * 8'd40 + 8'd55;
    endfunction

endpackage

// ===== sv/sgr_color_attribute_tracker.sv =====
// Tracks ANSI SGR colour attributes, one parameter per beat with s_last on the
// final parameter of each sequence, and returns one beat of current foreground,
// background and inverse state for every parameter taken. One beat is accepted
// every cycle while the output does not stall; a result is presented on the m_
// side once its parameter has passed the input register and then the output
// register, which loads through the attribute update and xterm-256 colour
// lookup. The attribute loop closes through the attribute register, which sets
// the clock rate.
module sgr_color_attribute_tracker #(
    parameter int unsigned PARAM_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PARAM_BITS-1:0] s_param,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [23:0]           m_fg_rgb,
    output logic [23:0]           m_bg_rgb,
    output logic                  m_inverse_on,
    output logic                  m_seq_done
);

    logic                  in_vld_reg, in_vld_next;
    logic [PARAM_BITS-1:0] in_param_reg;
    logic                  in_last_reg;
    logic                  out_vld_reg, out_vld_next;
    sgrcat_pkg::attr_t     out_attr_reg;
    logic                  out_done_reg;
    sgrcat_pkg::attr_t     attr_next;
    logic                  advance;
    logic                  s_take;

    sgrcat_state #(
        .PARAM_BITS (PARAM_BITS)
    ) u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .param     (in_param_reg),
        .last      (in_last_reg),
        .attr_next (attr_next)
    );

    always_comb begin
        advance = in_vld_reg && (!out_vld_reg || m_ready);
        s_ready = !in_vld_reg || advance;
        s_take = s_valid && s_ready;
        if (s_take)       in_vld_next = 1'b1;
        else if (advance) in_vld_next = 1'b0;
        else              in_vld_next = in_vld_reg;
        if (advance)      out_vld_next = 1'b1;
        else if (m_ready) out_vld_next = 1'b0;
        else              out_vld_next = out_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_param_reg <= s_param;
            in_last_reg <= s_last;
        end
        if (advance) begin
            out_attr_reg <= attr_next;
            out_done_reg <= in_last_reg;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_fg_rgb = out_attr_reg.fg;
    assign m_bg_rgb = out_attr_reg.bg;
    assign m_inverse_on = out_attr_reg.inv;
    assign m_seq_done = out_done_reg;

    // a held beat is never dropped while the output stalls
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg)
        else $error("input beat lost while stalled");

    a_adv_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg)
        else $error("processed beat did not reach output register");

    a_stall_block: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_vld_reg && !m_ready |-> !s_ready)
        else $error("new beat accepted while both stages full and stalled");

endmodule

// ===== sv/sgrcat_xterm_lut.sv =====
module sgrcat_xterm_lut (
    input  logic [7:0]  idx,
    output logic [23:0] rgb
);

    logic [7:0] k;
    logic [7:0] m;
    logic [2:0] cr;
    logic [2:0] cg;
    logic [2:0] cb;
    logic [7:0] gray;

    always_comb begin
        k = idx - sgrcat_pkg::CUBE_FIRST;
        if (k >= 8'd180)      cr = 3'd5;
        else if (k >= 8'd144) cr = 3'd4;
        else if (k >= 8'd108) cr = 3'd3;
        else if (k >= 8'd72)  cr = 3'd2;
        else if (k >= 8'd36)  cr = 3'd1;
        else                  cr = 3'd0;
        m = k - 8'(cr) * 8'd36;
        if (m >= 8'd30)      cg = 3'd5;
        else if (m >= 8'd24) cg = 3'd4;
        else if (m >= 8'd18) cg = 3'd3;
        else if (m >= 8'd12) cg = 3'd2;
        else if (m >= 8'd6)  cg = 3'd1;
        else                 cg = 3'd0;
        cb = 3'(m - 8'(cg) * 8'd6);
        gray = (idx - sgrcat_pkg::GRAY_FIRST) * 8'd10 + 8'd8;

        if (idx < 8'd8) begin
            rgb = sgrcat_pkg::palette(idx[2:0]);
        end else if (idx < sgrcat_pkg::CUBE_FIRST) begin
            rgb = sgrcat_pkg::palette(idx[2:0]) | sgrcat_pkg::BRIGHT;
        end else if (idx < sgrcat_pkg::GRAY_FIRST) begin
            rgb = {sgrcat_pkg::cube_level(cr), sgrcat_pkg::cube_level(cg),
                   sgrcat_pkg::cube_level(cb)};
        end else begin
            rgb = {gray, gray, gray};
        end
    end

endmodule

// ===== sv/sgrcat_state.sv =====
module sgrcat_state #(
    parameter int unsigned PARAM_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [PARAM_BITS-1:0] param,
    input  logic                  last,
    output sgrcat_pkg::attr_t     attr_next
);

    localparam int unsigned HELD_BITS =
        (PARAM_BITS < sgrcat_pkg::HELD_MAX_BITS) ? PARAM_BITS : sgrcat_pkg::HELD_MAX_BITS;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEL,
        PH_IDX,
        PH_R,
        PH_G,
        PH_B
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic                    tgt_bg_reg, tgt_bg_next;
    logic [HELD_BITS-1:0]    held_r_reg, held_r_next;
    logic [7:0]              held_g_reg, held_g_next;
    sgrcat_pkg::attr_t       attr_reg;

    logic [sgrcat_pkg::CODE_BITS-1:0] p;
    logic [23:0]             lut_rgb;
    logic [23:0]             set_rgb;
    logic                    do_set;
    logic                    is_ext;

    sgrcat_xterm_lut u_lut (
        .idx (param[7:0]),
        .rgb (lut_rgb)
    );

    always_comb begin
        p = sgrcat_pkg::CODE_BITS'(param);
        is_ext = (p == sgrcat_pkg::CODE_FG_EXT) || (p == sgrcat_pkg::CODE_BG_EXT);
        phase_next = PH_IDLE;
        tgt_bg_next = tgt_bg_reg;
        held_r_next = held_r_reg;
        held_g_next = held_g_reg;
        attr_next = attr_reg;
        do_set = 1'b0;
        set_rgb = lut_rgb;

        case (phase_reg)
            PH_SEL: begin
                if (p == sgrcat_pkg::SEL_INDEXED && !last) begin
                    phase_next = PH_IDX;
                end else if (p == sgrcat_pkg::SEL_DIRECT && !last) begin
                    phase_next = PH_R;
                end else if (is_ext && !last) begin
                    phase_next = PH_SEL;
                    tgt_bg_next = (p == sgrcat_pkg::CODE_BG_EXT);
                end else begin
                    attr_next = sgrcat_pkg::plain_code(attr_reg, p);
                end
            end
            PH_IDX: begin
                do_set = 1'b1;
            end
            PH_R: begin
                if (last) begin
                    attr_next = sgrcat_pkg::plain_code(attr_reg, p);
                end else begin
                    held_r_next = param[HELD_BITS-1:0];
                    phase_next = PH_G;
                end
            end
            PH_G: begin
                if (last) begin
                    attr_next = sgrcat_pkg::plain_code(
                        sgrcat_pkg::plain_code(attr_reg,
                                               sgrcat_pkg::CODE_BITS'(held_r_reg)), p);
                end else begin
                    held_g_next = param[7:0];
                    phase_next = PH_B;
                end
            end
            PH_B: begin
                do_set = 1'b1;
                set_rgb = {held_r_reg[7:0], held_g_reg, param[7:0]};
            end
            default: begin
                if (is_ext && !last) begin
                    phase_next = PH_SEL;
                    tgt_bg_next = (p == sgrcat_pkg::CODE_BG_EXT);
                end else begin
                    attr_next = sgrcat_pkg::plain_code(attr_reg, p);
                end
            end
        endcase

        if (do_set) begin
            if (tgt_bg_reg) attr_next.bg = set_rgb;
            else            attr_next.fg = set_rgb;
        end
        if (last) phase_next = PH_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tgt_bg_reg <= 1'b0;
            held_r_reg <= '0;
            held_g_reg <= '0;
            attr_reg <= '{fg: sgrcat_pkg::WHITE, bg: sgrcat_pkg::BLACK, inv: 1'b0};
        end else if (step) begin
            phase_reg <= phase_next;
            tgt_bg_reg <= tgt_bg_next;
            held_r_reg <= held_r_next;
            held_g_reg <= held_g_next;
            attr_reg <= attr_next;
        end
    end

endmodule

// ===== verif/sgr_attr_checker.sv =====
module sgr_attr_checker #(
    parameter int unsigned PARAM_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [PARAM_BITS-1:0] s_param,
    input  logic                  s_last,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [23:0]           m_fg_rgb,
    input  logic [23:0]           m_bg_rgb,
    input  logic                  m_inverse_on,
    input  logic                  m_seq_done,
    output int                    mismatches,
    output int                    results_seen,
    output int                    outstanding
);

    typedef enum logic [2:0] {
        EXT_IDLE,
        EXT_SEL,
        EXT_IDX,
        EXT_RED,
        EXT_GREEN,
        EXT_BLUE
    } ext_phase_t;

    typedef struct packed {
        logic [23:0] fg;
        logic [23:0] bg;
        logic        inv;
        logic        done;
    } attr_beat_t;

    logic [23:0]     fg_now;
    logic [23:0]     bg_now;
    logic            inv_now;
    ext_phase_t      phase;
    logic            to_bg;
    logic [15:0]     held_r;
    logic [15:0]     held_g;
    attr_beat_t      expected_attrs[$];

    function automatic logic [23:0] base_colour(input logic [2:0] i);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = i[0] ? 8'hAA : 8'h00;
        g = i[1] ? ((i == 3'd3) ? 8'h55 : 8'hAA) : 8'h00;
        b = i[2] ? 8'hAA : 8'h00;
        return {r, g, b};
    endfunction

    function automatic logic [7:0] level(input int v);
        return (v == 0) ? 8'd0 : 8'(v * 40 + 55);
    endfunction

    function automatic logic [23:0] xterm_colour(input logic [7:0] c);
        int k;
        if (c < 8'd8) begin
            return base_colour(c[2:0]);
        end
        if (c < sgrcat_pkg::CUBE_FIRST) begin
            return base_colour(c[2:0]) | sgrcat_pkg::BRIGHT;
        end
        if (c < sgrcat_pkg::GRAY_FIRST) begin
            k = int'(c) - int'(sgrcat_pkg::CUBE_FIRST);
            return {level(k / 36), level((k / 6) % 6), level(k % 6)};
        end
        k = (int'(c) - int'(sgrcat_pkg::GRAY_FIRST)) * 10 + 8;
        return {3{8'(k)}};
    endfunction

    function automatic void apply_code(input logic [31:0] c);
        if (c == sgrcat_pkg::CODE_RESET) begin
            fg_now = sgrcat_pkg::WHITE;
            bg_now = sgrcat_pkg::BLACK;
            inv_now = 1'b0;
        end else if (c >= sgrcat_pkg::CODE_FG_BASE && c <= sgrcat_pkg::CODE_FG_LAST) begin
            fg_now = base_colour(3'(c - sgrcat_pkg::CODE_FG_BASE));
        end else if (c >= sgrcat_pkg::CODE_BG_BASE && c <= sgrcat_pkg::CODE_BG_LAST) begin
            bg_now = base_colour(3'(c - sgrcat_pkg::CODE_BG_BASE));
        end else if (c == sgrcat_pkg::CODE_FG_DEFAULT) begin
            fg_now = sgrcat_pkg::WHITE;
        end else if (c == sgrcat_pkg::CODE_BG_DEFAULT) begin
            bg_now = sgrcat_pkg::BLACK;
        end else if (c >= sgrcat_pkg::CODE_FG_BRIGHT_BASE &&
                     c <= sgrcat_pkg::CODE_FG_BRIGHT_LAST) begin
            fg_now = base_colour(3'(c - sgrcat_pkg::CODE_FG_BRIGHT_BASE)) | sgrcat_pkg::BRIGHT;
        end else if (c >= sgrcat_pkg::CODE_BG_BRIGHT_BASE &&
                     c <= sgrcat_pkg::CODE_BG_BRIGHT_LAST) begin
            bg_now = base_colour(3'(c - sgrcat_pkg::CODE_BG_BRIGHT_BASE)) | sgrcat_pkg::BRIGHT;
        end else if (c == sgrcat_pkg::CODE_INVERSE_ON) begin
            inv_now = 1'b1;
        end else if (c == sgrcat_pkg::CODE_INVERSE_OFF) begin
            inv_now = 1'b0;
        end
    endfunction

    function automatic void open_param(input logic [31:0] c, input logic lst);
        if ((c == sgrcat_pkg::CODE_FG_EXT || c == sgrcat_pkg::CODE_BG_EXT) && !lst) begin
            phase = EXT_SEL;
            to_bg = (c == sgrcat_pkg::CODE_BG_EXT);
        end else begin
            apply_code(c);
        end
    endfunction

    function automatic void set_colour(input logic [23:0] rgb);
        if (to_bg) begin
            bg_now = rgb;
        end else begin
            fg_now = rgb;
        end
    endfunction

    function automatic void advance_attrs(input logic [31:0] c, input logic lst);
        ext_phase_t was;
        was = phase;
        phase = EXT_IDLE;
        case (was)
            EXT_SEL: begin
                if (c == sgrcat_pkg::SEL_INDEXED && !lst) begin
                    phase = EXT_IDX;
                end else if (c == sgrcat_pkg::SEL_DIRECT && !lst) begin
                    phase = EXT_RED;
                end else begin
                    open_param(c, lst);
                end
            end
            EXT_IDX: begin
                set_colour(xterm_colour(c[7:0]));
            end
            EXT_RED: begin
                if (lst) begin
                    apply_code(c);
                end else begin
                    held_r = c[15:0];
                    phase = EXT_GREEN;
                end
            end
            EXT_GREEN: begin
                // cut short: held red and this value act as plain codes
                if (lst) begin
                    apply_code(32'(held_r));
                    apply_code(c);
                end else begin
                    held_g = c[15:0];
                    phase = EXT_BLUE;
                end
            end
            EXT_BLUE: begin
                set_colour({held_r[7:0], held_g[7:0], c[7:0]});
            end
            default: begin
                open_param(c, lst);
            end
        endcase
        if (lst) begin
            phase = EXT_IDLE;
        end
    endfunction

    always @(posedge aclk) begin : watch
        attr_beat_t got;
        attr_beat_t want;
        if (!aresetn) begin
            fg_now = sgrcat_pkg::WHITE;
            bg_now = sgrcat_pkg::BLACK;
            inv_now = 1'b0;
            phase = EXT_IDLE;
            to_bg = 1'b0;
            held_r = '0;
            held_g = '0;
            expected_attrs.delete();
            mismatches = 0;
            results_seen = 0;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_fg_rgb, m_bg_rgb, m_inverse_on, m_seq_done};
                results_seen++;
                if (expected_attrs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat fg=%06h bg=%06h inv=%0b done=%0b",
                                 got.fg, got.bg, got.inv, got.done);
                    end
                end else begin
                    want = expected_attrs.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d: expected fg=%06h bg=%06h inv=%0b done=%0b",
                                     results_seen, want.fg, want.bg, want.inv, want.done);
                            $display("result %0d: actual   fg=%06h bg=%06h inv=%0b done=%0b",
                                     results_seen, got.fg, got.bg, got.inv, got.done);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_attrs(32'(s_param), s_last);
                expected_attrs.push_back('{fg_now, bg_now, inv_now, s_last});
            end
            outstanding <= expected_attrs.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;

    localparam int unsigned PARAM_BITS = 16;
    localparam int ITEMS = 750;
    localparam int LIMIT = 200000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [PARAM_BITS-1:0] s_param;
    logic                  s_last;
    logic                  m_valid;
    logic                  m_ready;
    logic [23:0]           m_fg_rgb;
    logic [23:0]           m_bg_rgb;
    logic                  m_inverse_on;
    logic                  m_seq_done;

    int mismatches;
    int results_seen;
    int outstanding;

    int   cycles;
    int   beats_sent;
    int   directed_beats;
    int   sequences;
    int   cut_sequences;
    logic quiet;
    logic [15:0] run_params[$];

    sgr_color_attribute_tracker #(
        .PARAM_BITS(PARAM_BITS)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_param(s_param),
        .s_last(s_last),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_fg_rgb(m_fg_rgb),
        .m_bg_rgb(m_bg_rgb),
        .m_inverse_on(m_inverse_on),
        .m_seq_done(m_seq_done)
    );

    sgr_attr_checker #(
        .PARAM_BITS(PARAM_BITS)
    ) u_attr_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_param(s_param),
        .s_last(s_last),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_fg_rgb(m_fg_rgb),
        .m_bg_rgb(m_bg_rgb),
        .m_inverse_on(m_inverse_on),
        .m_seq_done(m_seq_done),
        .mismatches(mismatches),
        .results_seen(results_seen),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("run stopped after %0d cycles, %0d results outstanding",
                     cycles, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : result_side
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_param(input logic [15:0] p, input logic l);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_param <= p;
        s_last <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] ext_code();
        return $urandom_range(0, 1) ? 16'(sgrcat_pkg::CODE_BG_EXT)
                                    : 16'(sgrcat_pkg::CODE_FG_EXT);
    endfunction

    function automatic logic [15:0] plain_pick();
        logic [31:0] c;
        case ($urandom_range(0, 10))
            0: c = sgrcat_pkg::CODE_RESET;
            1: c = sgrcat_pkg::CODE_INVERSE_ON;
            2: c = sgrcat_pkg::CODE_INVERSE_OFF;
            3: c = sgrcat_pkg::CODE_FG_BASE + $urandom_range(0, 7);
            4: c = sgrcat_pkg::CODE_BG_BASE + $urandom_range(0, 7);
            5: c = sgrcat_pkg::CODE_FG_DEFAULT;
            6: c = sgrcat_pkg::CODE_BG_DEFAULT;
            7: c = sgrcat_pkg::CODE_FG_BRIGHT_BASE + $urandom_range(0, 7);
            8: c = sgrcat_pkg::CODE_BG_BRIGHT_BASE + $urandom_range(0, 7);
            9: c = $urandom_range(0, 127);
            default: c = 32'(ext_code());
        endcase
        return c[15:0];
    endfunction

    task automatic build_sequence();
        int groups;
        int keep;
        run_params.delete();
        groups = $urandom_range(1, 4);
        repeat (groups) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    run_params.push_back(plain_pick());
                end
                4, 5: begin
                    run_params.push_back(ext_code());
                    run_params.push_back(16'(sgrcat_pkg::SEL_INDEXED));
                    run_params.push_back(16'($urandom));
                end
                6, 7: begin
                    run_params.push_back(ext_code());
                    run_params.push_back(16'(sgrcat_pkg::SEL_DIRECT));
                    repeat (3) run_params.push_back(16'($urandom));
                end
                8: begin
                    run_params.push_back(16'($urandom));
                end
                default: begin
                    run_params.push_back(ext_code());
                    run_params.push_back(16'($urandom_range(0, 9)));
                end
            endcase
        end
        // sometimes cut the sequence short, possibly in the middle of an extended colour
        if ($urandom_range(0, 4) == 0) begin
            keep = $urandom_range(1, run_params.size());
            while (run_params.size() > keep) void'(run_params.pop_back());
            cut_sequences++;
        end
    endtask

    initial begin : stimulus
        logic mid_drained;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_param = '0;
        s_last = 1'b0;
        quiet = 1'b0;
        beats_sent = 0;
        sequences = 0;
        cut_sequences = 0;
        mid_drained = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // plain codes at the ends of each range, with defaults, inverse, a final 38 and an unknown code
        send_param(16'(sgrcat_pkg::CODE_INVERSE_ON), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_FG_BASE), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_BG_LAST), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_FG_BRIGHT_LAST), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_BG_BRIGHT_BASE), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_FG_EXT), 1'b1);
        send_param(16'(sgrcat_pkg::CODE_FG_LAST), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_BG_BASE), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_FG_BRIGHT_BASE), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_BG_BRIGHT_LAST), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_FG_DEFAULT), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_BG_DEFAULT), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_INVERSE_OFF), 1'b0);
        send_param(16'hFFFF, 1'b1);
        // bad selector restarting an extended colour, index with high bits set, then a sequence ending on its selector
        send_param(16'(sgrcat_pkg::CODE_BG_EXT), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_FG_EXT), 1'b0);
        send_param(16'(sgrcat_pkg::SEL_INDEXED), 1'b0);
        send_param(16'hFFFF, 1'b1);
        send_param(16'(sgrcat_pkg::CODE_BG_EXT), 1'b0);
        send_param(16'(sgrcat_pkg::SEL_INDEXED), 1'b1);
        // direct colour cut short after red, then after green
        send_param(16'(sgrcat_pkg::CODE_FG_EXT), 1'b0);
        send_param(16'(sgrcat_pkg::SEL_DIRECT), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_FG_BASE + 1), 1'b1);
        send_param(16'(sgrcat_pkg::CODE_BG_EXT), 1'b0);
        send_param(16'(sgrcat_pkg::SEL_DIRECT), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_BG_BASE + 1), 1'b0);
        send_param(16'(sgrcat_pkg::CODE_INVERSE_ON), 1'b1);
        send_param(16'(sgrcat_pkg::CODE_RESET), 1'b1);
        directed_beats = beats_sent;
        drain();

        while (beats_sent < ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                quiet = ~quiet;
            end
            if (!mid_drained && beats_sent >= ITEMS / 2) begin
                drain();
                mid_drained = 1'b1;
            end
            build_sequence();
            sequences++;
            foreach (run_params[i]) begin
                send_param(run_params[i], i == run_params.size() - 1);
            end
        end

        drain();
        repeat (6) @(posedge aclk);
        $display("%0d parameter beats (%0d directed), %0d random sequences, %0d cut short",
                 beats_sent, directed_beats, sequences, cut_sequences);
        $display("%0d result beats compared, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/sgrcat_pkg.sv
sv/sgrcat_xterm_lut.sv
sv/sgrcat_state.sv
sv/sgr_color_attribute_tracker.sv
verif/sgr_attr_checker.sv
verif/testbench.sv
